// File: src/rprop_swu_pkg.sv
// rprop_swu_pkg: shared constants and types for the synapse weight updater
// holds operation codes, configuration indexes, field widths and reset values
// no dependencies
`timescale 1ns / 1ps

package rprop_swu_pkg;

    // default sizing of the synapse table and the value path
    localparam int SYNAPSES_DEFAULT    = 256;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int INDEX_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int FRAC_BITS  = 16;

    // configuration register widths
    localparam int RATE_W   = 17;
    localparam int FACTOR_W = 19;
    localparam int STEP_W   = 31;

    // operation codes carried by an input word
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ADD    = 2'd1,
        OP_LEARN  = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    // learning rule selection
    localparam logic ALG_BACKPROP = 1'b0;
    localparam logic ALG_RPROP    = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INCREASE_FACTOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECREASE_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MAX        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MIN        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STEP    = 3'd7;

    // configuration reset values
    localparam logic                RST_ALGORITHM       = ALG_RPROP;
    localparam logic [RATE_W-1:0]   RST_LEARN_RATE      = 17'd45875;
    localparam logic [RATE_W-1:0]   RST_MOMENTUM        = 17'd19661;
    localparam logic [FACTOR_W-1:0] RST_INCREASE_FACTOR = 19'd78643;
    localparam logic [RATE_W-1:0]   RST_DECREASE_FACTOR = 17'd32768;
    localparam logic [STEP_W-1:0]   RST_STEP_MAX        = 31'd3276800;
    localparam logic [STEP_W-1:0]   RST_STEP_MIN        = 31'd1;
    localparam logic [STEP_W-1:0]   RST_INITIAL_STEP    = 31'd6554;

endpackage

// File: src/rprop_swu_ram.sv
// rprop_swu_ram: generic single write port, single read port memory
// read data is registered and only updated on a read enable
// no dependencies
`timescale 1ns / 1ps

module rprop_swu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/rprop_synapse_weight_updater_top.sv
// rprop_synapse_weight_updater_top: synapse table with backprop and rprop updates
// depends on rprop_swu_pkg and rprop_swu_ram
`timescale 1ns / 1ps

// Usage
//   input channel: i_in_valid / o_in_ready move one word of operation,
//   synapse index and value (load weight, add batch gradient, learn step).
//   output channel: o_out_valid / i_out_ready move one word per input word,
//   the addressed synapse's weight after the operation, in input order.
//   configuration: i_cfg_wr_en writes i_cfg_wr_data into register
//   i_cfg_index; write only while no word is in flight.
// Flow
//   a result is presented from the result register and held until taken.
//   one word per cycle is sustained while the receiver does not stall:
//   each word does one read-modify-write of its synapse entry in the
//   entry RAM, the RAM read issued at accept and the write-back as the
//   word leaves the compute stage, with the written entry forwarded
//   to a word of the same index that is read in that cycle.
// Reset and stall
//   reset clears the pipeline and loads configuration defaults; the entry
//   RAM is not cleared, so a synapse must be loaded before its first use.
//   when the receiver stalls, the result register holds, one more word is
//   taken into the compute stage, then o_in_ready drops until it drains.
module rprop_synapse_weight_updater_top #(
    parameter int SYNAPSES    = rprop_swu_pkg::SYNAPSES_DEFAULT,
    parameter int VALUE_WIDTH = rprop_swu_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration port
    input  logic                                  i_cfg_wr_en,
    input  logic [rprop_swu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rprop_swu_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [rprop_swu_pkg::OP_W-1:0]        i_operation,
    input  logic [rprop_swu_pkg::INDEX_W-1:0]     i_synapse_index,
    input  logic signed [VALUE_WIDTH-1:0]         i_value,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [VALUE_WIDTH-1:0]         o_current_weight
);

    localparam int VW   = VALUE_WIDTH;
    localparam int FW   = rprop_swu_pkg::FACTOR_W;
    localparam int AW   = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
    localparam int PW   = VW + FW;
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [PW-1:0] HALF_LSB = PW'(1) << (rprop_swu_pkg::FRAC_BITS - 1);

    typedef struct packed {
        logic signed [VW-1:0] weight;
        logic signed [VW-1:0] pend_weight;
        logic signed [VW-1:0] step;
        logic signed [VW-1:0] prev_step;
        logic signed [VW-1:0] delta;
        logic signed [VW-1:0] prev_delta;
        logic signed [VW-1:0] grad_acc;
        logic signed [VW-1:0] prev_grad_sum;
        logic signed [VW-1:0] mom_delta;
    } t_entry;

    localparam int EW = $bits(t_entry);

    // saturating add
    function automatic logic signed [VW-1:0] sat_add(
        input logic signed [VW-1:0] a,
        input logic signed [VW-1:0] b
    );
        logic signed [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1]) begin
            sat_add = s[VW] ? VMIN : VMAX;
        end else begin
            sat_add = s[VW-1:0];
        end
    endfunction

    // saturating negate
    function automatic logic signed [VW-1:0] sat_neg(input logic signed [VW-1:0] a);
        sat_neg = (a == VMIN) ? VMAX : -a;
    endfunction

    // signed value times unsigned q3.16 factor, rounded half away from zero
    function automatic logic signed [VW-1:0] fx_mul(
        input logic signed [VW-1:0] a,
        input logic [FW-1:0]        f
    );
        logic          neg;
        logic [VW-1:0] mag;
        logic [VW-1:0] cap;
        logic [PW-1:0] prod;
        logic [PW-1:0] p;
        logic [VW-1:0] r;
        neg  = a[VW-1];
        mag  = neg ? (~a + VW'(1)) : a;
        cap  = neg ? VMIN : VMAX;
        prod = PW'(mag) * PW'(f);
        p    = (prod + HALF_LSB) >> rprop_swu_pkg::FRAC_BITS;
        r    = (p > PW'(cap)) ? cap : p[VW-1:0];
        fx_mul = neg ? -r : r;
    endfunction

    // unsigned configuration step clamped into the value range
    function automatic logic signed [VW-1:0] clamp_cfg(
        input logic [rprop_swu_pkg::STEP_W-1:0] v
    );
        logic [63:0] vx;
        logic [63:0] mx;
        vx = 64'(v);
        mx = 64'(VMAX);
        clamp_cfg = (vx > mx) ? VMAX : VW'(v);
    endfunction

    // configuration registers
    logic                                   r_algorithm;
    logic [rprop_swu_pkg::RATE_W-1:0]       r_learn_rate;
    logic [rprop_swu_pkg::RATE_W-1:0]       r_momentum;
    logic [FW-1:0]                          r_increase_factor;
    logic [rprop_swu_pkg::RATE_W-1:0]       r_decrease_factor;
    logic [rprop_swu_pkg::STEP_W-1:0]       r_step_max;
    logic [rprop_swu_pkg::STEP_W-1:0]       r_step_min;
    logic [rprop_swu_pkg::STEP_W-1:0]       r_initial_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_algorithm       <= rprop_swu_pkg::RST_ALGORITHM;
            r_learn_rate      <= rprop_swu_pkg::RST_LEARN_RATE;
            r_momentum        <= rprop_swu_pkg::RST_MOMENTUM;
            r_increase_factor <= rprop_swu_pkg::RST_INCREASE_FACTOR;
            r_decrease_factor <= rprop_swu_pkg::RST_DECREASE_FACTOR;
            r_step_max        <= rprop_swu_pkg::RST_STEP_MAX;
            r_step_min        <= rprop_swu_pkg::RST_STEP_MIN;
            r_initial_step    <= rprop_swu_pkg::RST_INITIAL_STEP;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rprop_swu_pkg::CFG_ALGORITHM:       r_algorithm <= i_cfg_wr_data[0];
                rprop_swu_pkg::CFG_LEARN_RATE:      r_learn_rate <= i_cfg_wr_data[16:0];
                rprop_swu_pkg::CFG_MOMENTUM:        r_momentum <= i_cfg_wr_data[16:0];
                rprop_swu_pkg::CFG_INCREASE_FACTOR: r_increase_factor <= i_cfg_wr_data[18:0];
                rprop_swu_pkg::CFG_DECREASE_FACTOR: r_decrease_factor <= i_cfg_wr_data[16:0];
                rprop_swu_pkg::CFG_STEP_MAX:        r_step_max <= i_cfg_wr_data;
                rprop_swu_pkg::CFG_STEP_MIN:        r_step_min <= i_cfg_wr_data;
                rprop_swu_pkg::CFG_INITIAL_STEP:    r_initial_step <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // pipeline registers
    logic                   r_s1_valid;
    logic [rprop_swu_pkg::OP_W-1:0] r_s1_op;
    logic signed [VW-1:0]   r_s1_value;
    logic [AW-1:0]          r_s1_addr;
    logic                   r_s1_oob;
    logic                   r_s1_fwd;
    t_entry                 r_fwd_entry;
    logic                   r_out_valid;
    logic signed [VW-1:0]   r_out_weight;

    logic                   s1_adv;
    logic                   in_accept;
    logic [AW-1:0]          in_addr;
    logic                   in_oob;
    logic                   wr_en;
    logic [EW-1:0]          ram_rd_data;
    t_entry                 cur;
    t_entry                 n_entry;
    logic signed [VW-1:0]   n_result;

    // handshake
    assign s1_adv    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept = i_in_valid && o_in_ready;
    assign in_addr   = AW'(i_synapse_index);
    assign in_oob    = 32'(i_synapse_index) >= 32'(SYNAPSES);
    assign wr_en     = s1_adv && !r_s1_oob
                       && (r_s1_op != rprop_swu_pkg::OP_UNUSED);

    // entry store
    rprop_swu_ram #(
        .WIDTH (EW),
        .DEPTH (SYNAPSES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (n_entry),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_addr),
        .o_rd_data (ram_rd_data)
    );

    // entry read with forwarding of the word written in the read cycle
    assign cur = r_s1_fwd ? r_fwd_entry : t_entry'(ram_rd_data);

    // update datapath
    logic signed [VW-1:0] rp_g;
    logic                 g_pos, g_neg, ps_pos, ps_neg, s_pos, s_neg;
    logic signed [VW-1:0] mul_a;
    logic [FW-1:0]        mul_f;
    logic signed [VW-1:0] mul_a_res;
    logic signed [VW-1:0] mul_m_res;
    logic signed [VW-1:0] bp_m;
    logic signed [VW-1:0] lim_max;
    logic signed [VW-1:0] lim_min;
    logic signed [VW-1:0] ns_up;
    logic signed [VW-1:0] ns_dn;
    logic signed [VW-1:0] new_delta;

    always_comb begin
        // rprop sign agreement
        rp_g   = sat_neg(cur.grad_acc);
        g_pos  = !rp_g[VW-1] && (rp_g != '0);
        g_neg  = rp_g[VW-1];
        ps_pos = !cur.prev_grad_sum[VW-1] && (cur.prev_grad_sum != '0);
        ps_neg = cur.prev_grad_sum[VW-1];
        s_pos  = (g_pos && ps_pos) || (g_neg && ps_neg);
        s_neg  = (g_pos && ps_neg) || (g_neg && ps_pos);

        // shared multiplier: step factor for rprop, learn rate for backprop
        if (r_algorithm == rprop_swu_pkg::ALG_RPROP) begin
            mul_a = cur.prev_step;
            mul_f = s_pos ? r_increase_factor : FW'(r_decrease_factor);
        end else begin
            mul_a = cur.grad_acc;
            mul_f = FW'(r_learn_rate);
        end
        mul_a_res = fx_mul(mul_a, mul_f);
        mul_m_res = fx_mul(cur.mom_delta, FW'(r_momentum));
        bp_m      = sat_add(mul_a_res, mul_m_res);

        // step bounds
        lim_max = clamp_cfg(r_step_max);
        lim_min = clamp_cfg(r_step_min);
        ns_up   = (mul_a_res > lim_max) ? lim_max : mul_a_res;
        ns_dn   = (mul_a_res < lim_min) ? lim_min : mul_a_res;

        n_entry   = cur;
        new_delta = '0;
        case (r_s1_op)
            rprop_swu_pkg::OP_LOAD: begin
                n_entry.weight        = r_s1_value;
                n_entry.pend_weight   = r_s1_value;
                n_entry.step          = clamp_cfg(r_initial_step);
                n_entry.prev_step     = clamp_cfg(r_initial_step);
                n_entry.delta         = '0;
                n_entry.prev_delta    = '0;
                n_entry.grad_acc      = '0;
                n_entry.prev_grad_sum = '0;
                n_entry.mom_delta     = '0;
            end
            rprop_swu_pkg::OP_ADD: begin
                n_entry.grad_acc = sat_add(cur.grad_acc, r_s1_value);
            end
            rprop_swu_pkg::OP_LEARN: begin
                n_entry.grad_acc = '0;
                if (r_algorithm == rprop_swu_pkg::ALG_BACKPROP) begin
                    n_entry.mom_delta = bp_m;
                    n_entry.weight    = sat_add(cur.weight, bp_m);
                end else begin
                    n_entry.weight        = cur.pend_weight;
                    n_entry.prev_grad_sum = rp_g;
                    if (s_pos) begin
                        // sign held: grow from the step before last
                        new_delta          = g_pos ? -ns_up : (g_neg ? ns_up : '0);
                        n_entry.prev_step  = cur.step;
                        n_entry.step       = ns_up;
                        n_entry.prev_delta = cur.delta;
                        n_entry.delta      = new_delta;
                        n_entry.pend_weight = sat_add(cur.pend_weight, new_delta);
                    end else if (s_neg) begin
                        // sign change: shrink and backtrack
                        n_entry.step          = ns_dn;
                        n_entry.pend_weight   = sat_add(cur.pend_weight,
                                                        sat_neg(cur.prev_delta));
                        n_entry.prev_grad_sum = '0;
                    end else begin
                        new_delta = g_pos ? sat_neg(cur.step) : (g_neg ? cur.step : '0);
                        n_entry.prev_delta  = cur.delta;
                        n_entry.delta       = new_delta;
                        n_entry.pend_weight = sat_add(cur.pend_weight, new_delta);
                    end
                end
            end
            default: ;
        endcase

        n_result = r_s1_oob ? '0 : n_entry.weight;
    end

    // compute stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
            r_s1_fwd   <= wr_en && (r_s1_addr == in_addr);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // compute stage payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op     <= i_operation;
            r_s1_value  <= i_value;
            r_s1_addr   <= in_addr;
            r_s1_oob    <= in_oob;
            r_fwd_entry <= n_entry;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_weight <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_current_weight = r_out_weight;

endmodule

// File: src/rprop_swu_checker.sv
// rprop_swu_checker: port level checks for the synapse weight updater
// bound to rprop_synapse_weight_updater_top; depends on rprop_swu_pkg
`timescale 1ns / 1ps

module rprop_swu_checker #(
    parameter int VALUE_WIDTH = rprop_swu_pkg::VALUE_WIDTH_DEFAULT
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [VALUE_WIDTH-1:0] i_current_weight
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_current_weight))
        else $error("result word changed or dropped while stalled");

    // reset empties the pipeline and opens the input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("pipeline not empty after reset");

    // after an accept, once the word has passed the compute stage, a result word is valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> ##1 i_out_valid)
        else $error("no result two cycles after accept");

    // with an empty result register the input is never blocked
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind rprop_synapse_weight_updater_top rprop_swu_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_rprop_swu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .i_in_ready       (o_in_ready),
    .i_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .i_current_weight (o_current_weight)
);

// File: test/testbench.sv
// testbench: self-checking bench for rprop_synapse_weight_updater_top
// predicts every returned weight from its own copy of the synapse table and config
// depends on rprop_swu_pkg and the synapse weight updater rtl
`timescale 1ns / 1ps

module testbench;

    import rprop_swu_pkg::*;

    localparam int VW = VALUE_WIDTH_DEFAULT;
    localparam int NSYN = SYNAPSES_DEFAULT;
    localparam longint VMAX = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam int IDLE_PCT = 21;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] idx;
        logic [VW-1:0]      value;
    } t_syn_word;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #4 clk = ~clk;
    end

    // dut ports
    logic                   cfg_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [OP_W-1:0]        op_d = '0;
    logic [INDEX_W-1:0]     idx_d = '0;
    logic signed [VW-1:0]   value_d = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic signed [VW-1:0]   weight_out;

    rprop_synapse_weight_updater_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_en),
        .i_cfg_index      (cfg_idx),
        .i_cfg_wr_data    (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_operation      (op_d),
        .i_synapse_index  (idx_d),
        .i_value          (value_d),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_current_weight (weight_out)
    );

    // shadow of the configuration registers
    logic   alg_cfg   = RST_ALGORITHM;
    longint rate_cfg  = RST_LEARN_RATE;
    longint mom_cfg   = RST_MOMENTUM;
    longint inc_cfg   = RST_INCREASE_FACTOR;
    longint dec_cfg   = RST_DECREASE_FACTOR;
    longint smax_cfg  = RST_STEP_MAX;
    longint smin_cfg  = RST_STEP_MIN;
    longint istep_cfg = RST_INITIAL_STEP;

    // shadow of the synapse table
    longint weight_q      [NSYN];
    longint pend_wt_q     [NSYN];
    longint step_q        [NSYN];
    longint prev_step_q   [NSYN];
    longint delta_q       [NSYN];
    longint prev_delta_q  [NSYN];
    longint grad_acc_q    [NSYN];
    longint last_sum_q    [NSYN];
    longint mom_delta_q   [NSYN];

    // words waiting to be sent and weights waiting to come back
    t_syn_word         pending_words[$];
    logic [VW-1:0]     weight_expect_q[$];

    int  in_count = 0;
    int  out_count = 0;
    int  mismatches = 0;
    int  phase_count = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    logic calm;

    // a stretch of the run where neither side idles
    assign calm = (in_count >= 1200) && (in_count < 1500);

    // stimulus bookkeeping
    bit [NSYN-1:0] loaded_map = '0;
    bit [NSYN-1:0] grad_neg = '0;
    int            n_loaded = 0;

    function automatic longint sat_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > VMAX) return VMAX;
        if (s < VMIN) return VMIN;
        return s;
    endfunction

    function automatic longint sat_neg(longint a);
        return (a <= VMIN) ? VMAX : -a;
    endfunction

    function automatic int sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // signed value times unsigned q16.16 factor, rounded half away from zero
    function automatic longint scale_q16(longint a, longint unsigned f);
        bit                neg;
        longint unsigned   mag, cap, hi, lo, r, part;
        neg = (a < 0);
        mag = neg ? longint'(-a) : a;
        cap = neg ? longint'(VMAX) + 1 : longint'(VMAX);
        hi = mag >> 16;
        lo = mag & 64'hFFFF;
        if (f != 0 && hi > cap / f) return neg ? VMIN : VMAX;
        r = hi * f;
        part = (lo * f + 64'h8000) >> 16;
        if (r > cap - part) r = cap;
        else r = r + part;
        if (neg) return (r == cap) ? VMIN : -longint'(r);
        return longint'(r);
    endfunction

    // one learn step of resilient propagation on entry i
    function automatic void rprop_learn(int i);
        longint g, ns;
        int     s;
        g = sat_neg(grad_acc_q[i]);
        s = sign_of(g) * sign_of(last_sum_q[i]);
        last_sum_q[i] = g;
        grad_acc_q[i] = 0;
        weight_q[i] = pend_wt_q[i];
        if (s > 0) begin
            // same sign: grow from the step before last
            ns = scale_q16(prev_step_q[i], inc_cfg);
            if (ns > smax_cfg) ns = smax_cfg;
            prev_step_q[i] = step_q[i];
            step_q[i] = ns;
            prev_delta_q[i] = delta_q[i];
            delta_q[i] = (g > 0) ? -ns : ((g < 0) ? ns : 0);
            pend_wt_q[i] = sat_add(weight_q[i], delta_q[i]);
        end else if (s < 0) begin
            // sign change: shrink and backtrack
            ns = scale_q16(prev_step_q[i], dec_cfg);
            if (ns < smin_cfg) ns = smin_cfg;
            step_q[i] = ns;
            pend_wt_q[i] = sat_add(weight_q[i], sat_neg(prev_delta_q[i]));
            last_sum_q[i] = 0;
        end else begin
            prev_delta_q[i] = delta_q[i];
            delta_q[i] = (g > 0) ? sat_neg(step_q[i]) : ((g < 0) ? step_q[i] : 0);
            pend_wt_q[i] = sat_add(weight_q[i], delta_q[i]);
        end
    endfunction

    // apply one word to the shadow table, return the weight it reports
    function automatic logic [VW-1:0] apply_word(t_syn_word w);
        int     i;
        longint v, m;
        i = w.idx;
        v = longint'($signed(w.value));
        case (w.op)
            OP_LOAD: begin
                weight_q[i] = v;
                pend_wt_q[i] = v;
                step_q[i] = istep_cfg;
                prev_step_q[i] = istep_cfg;
                delta_q[i] = 0;
                prev_delta_q[i] = 0;
                grad_acc_q[i] = 0;
                last_sum_q[i] = 0;
                mom_delta_q[i] = 0;
            end
            OP_ADD: begin
                grad_acc_q[i] = sat_add(grad_acc_q[i], v);
            end
            OP_LEARN: begin
                if (alg_cfg == ALG_BACKPROP) begin
                    m = sat_add(scale_q16(grad_acc_q[i], rate_cfg),
                                scale_q16(mom_delta_q[i], mom_cfg));
                    mom_delta_q[i] = m;
                    weight_q[i] = sat_add(weight_q[i], m);
                    grad_acc_q[i] = 0;
                end else begin
                    rprop_learn(i);
                end
            end
            default: ;
        endcase
        return weight_q[i][VW-1:0];
    endfunction

    // config shadow follows every register write
    always @(posedge clk) begin
        if (rst_n && cfg_en) begin
            case (cfg_idx)
                CFG_ALGORITHM:       alg_cfg <= cfg_data[0];
                CFG_LEARN_RATE:      rate_cfg <= longint'(cfg_data[RATE_W-1:0]);
                CFG_MOMENTUM:        mom_cfg <= longint'(cfg_data[RATE_W-1:0]);
                CFG_INCREASE_FACTOR: inc_cfg <= longint'(cfg_data[FACTOR_W-1:0]);
                CFG_DECREASE_FACTOR: dec_cfg <= longint'(cfg_data[RATE_W-1:0]);
                CFG_STEP_MAX:        smax_cfg <= longint'(cfg_data[STEP_W-1:0]);
                CFG_STEP_MIN:        smin_cfg <= longint'(cfg_data[STEP_W-1:0]);
                CFG_INITIAL_STEP:    istep_cfg <= longint'(cfg_data[STEP_W-1:0]);
                default: ;
            endcase
        end
    end

    // driver: predict on accept, then offer the next word or idle
    always @(posedge clk) begin : drive_proc
        t_syn_word w;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                w.op = op_d;
                w.idx = idx_d;
                w.value = value_d;
                weight_expect_q.insert(weight_expect_q.size(), apply_word(w));
                in_count <= in_count + 1;
            end
            if (!in_valid || in_ready) begin
                if (pending_words.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    w = pending_words.pop_front();
                    in_valid <= 1'b1;
                    op_d <= w.op;
                    idx_d <= w.idx;
                    value_d <= w.value;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off: one long stall so the pipe fills and backs up
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && in_count >= 600) begin
            hold_left <= 150;
            hold_done <= 1'b1;
        end
    end

    // receiver ready with random stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: compare each returned weight with the oldest prediction
    always @(posedge clk) begin : check_proc
        logic [VW-1:0] want;
        if (rst_n && out_valid && out_ready) begin
            out_count <= out_count + 1;
            if (weight_expect_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < MAX_SHOWN)
                    $display("error: weight %h returned with no word pending", weight_out);
            end else begin
                want = weight_expect_q.pop_front();
                if (weight_out !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_SHOWN)
                        $display("error: result %0d current_weight expected %h got %h",
                                 out_count, want, weight_out);
                end
            end
        end
    end

    // stimulus helpers
    task automatic queue_word(logic [OP_W-1:0] op, int idx, logic [VW-1:0] value);
        t_syn_word w;
        w.op = op;
        w.idx = idx[INDEX_W-1:0];
        w.value = value;
        pending_words.insert(pending_words.size(), w);
        if (op == OP_LOAD && !loaded_map[idx]) begin
            loaded_map[idx] = 1'b1;
            n_loaded++;
        end
    endtask

    function automatic int pick_loaded();
        int idx;
        idx = $urandom_range(0, NSYN - 1);
        while (!loaded_map[idx]) idx = $urandom_range(0, NSYN - 1);
        return idx;
    endfunction

    function automatic logic [VW-1:0] edge_value();
        case ($urandom_range(0, 4))
            0: return VMAX[VW-1:0];
            1: return VMIN[VW-1:0];
            2: return '0;
            3: return '1;
            default: return VW'(1);
        endcase
    endfunction

    // mostly moderate values, sometimes full width or extremes
    function automatic logic [VW-1:0] any_value();
        longint mag;
        case ($urandom_range(0, 9))
            0: return edge_value();
            1, 2: return $urandom();
            default: begin
                mag = $urandom_range(0, 1 << 20);
                return ($urandom_range(0, 1) != 0) ? VW'(-mag) : VW'(mag);
            end
        endcase
    endfunction

    function automatic logic [VW-1:0] gradient(bit neg);
        longint mag;
        if ($urandom_range(0, 19) == 0) return $urandom();
        mag = $urandom_range(1, 1 << 17);
        return neg ? VW'(-mag) : VW'(mag);
    endfunction

    // random part: mostly add bursts closed by a learn step, some noise
    task automatic fill_training(int count);
        int made, r, idx, nadd;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            if ((n_loaded < 24) ? (r < 30) : (r < 8)) begin
                queue_word(OP_LOAD, $urandom_range(0, NSYN - 1), any_value());
                made++;
            end else if (r < 70) begin
                idx = pick_loaded();
                if ($urandom_range(0, 99) < 30) grad_neg[idx] = ~grad_neg[idx];
                nadd = $urandom_range(0, 3);
                repeat (nadd) queue_word(OP_ADD, idx, gradient(grad_neg[idx]));
                queue_word(OP_LEARN, idx, $urandom());
                made += nadd + 1;
            end else if (r < 85) begin
                queue_word(($urandom_range(0, 1) != 0) ? OP_ADD : OP_LEARN,
                           pick_loaded(), any_value());
                made++;
            end else if (r < 92) begin
                queue_word(OP_UNUSED, pick_loaded(), $urandom());
                made++;
            end else begin
                idx = pick_loaded();
                queue_word(OP_ADD, idx, edge_value());
                queue_word(OP_LEARN, idx, '0);
                made += 2;
            end
        end
    endtask

    // idle point: every word sent and every weight back
    task automatic drain();
        while (pending_words.size() != 0 || weight_expect_q.size() != 0 || in_valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint data);
        @(posedge clk);
        cfg_en <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data[CFG_DATA_W-1:0];
    endtask

    task automatic set_config(logic alg, longint lr, longint mom, longint inc,
                              longint dec, longint smax, longint smin, longint istep);
        write_reg(CFG_ALGORITHM, alg);
        write_reg(CFG_LEARN_RATE, lr);
        write_reg(CFG_MOMENTUM, mom);
        write_reg(CFG_INCREASE_FACTOR, inc);
        write_reg(CFG_DECREASE_FACTOR, dec);
        write_reg(CFG_STEP_MAX, smax);
        write_reg(CFG_STEP_MIN, smin);
        write_reg(CFG_INITIAL_STEP, istep);
        @(posedge clk);
        cfg_en <= 1'b0;
        phase_count++;
    endtask

    task automatic run_phase(logic alg, longint lr, longint mom, longint inc,
                             longint dec, longint smax, longint smin, longint istep,
                             int count);
        drain();
        set_config(alg, lr, mom, inc, dec, smax, smin, istep);
        @(negedge clk);
        fill_training(count);
    endtask

    // main sequence
    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, saturation, each rprop branch, unused op
        queue_word(OP_LOAD, 0, VMAX[VW-1:0]);
        queue_word(OP_LOAD, NSYN - 1, VMIN[VW-1:0]);
        queue_word(OP_LOAD, 1, '0);
        queue_word(OP_LOAD, 2, 32'h0001_0000);
        queue_word(OP_ADD, 0, VMAX[VW-1:0]);
        queue_word(OP_ADD, 0, VMAX[VW-1:0]);
        queue_word(OP_ADD, NSYN - 1, VMIN[VW-1:0]);
        queue_word(OP_ADD, NSYN - 1, VMIN[VW-1:0]);
        queue_word(OP_LEARN, 0, '0);
        queue_word(OP_LEARN, NSYN - 1, '1);
        queue_word(OP_ADD, 2, -32'sd65536);
        queue_word(OP_LEARN, 2, '0);
        queue_word(OP_ADD, 2, -32'sd65536);
        queue_word(OP_LEARN, 2, '0);
        queue_word(OP_ADD, 2, 32'sd65536);
        queue_word(OP_LEARN, 2, '0);
        queue_word(OP_LEARN, 1, '0);
        queue_word(OP_UNUSED, 2, 32'h5A5A_A5A5);
        queue_word(OP_UNUSED, 0, '0);
        queue_word(OP_ADD, 1, '1);
        queue_word(OP_LEARN, 1, '0);
        queue_word(OP_LEARN, 0, '0);

        // random phases across the register space
        fill_training(400);
        run_phase(ALG_BACKPROP, 45875, 19661, 78643, 32768, 3276800, 1, 6554, 300);
        run_phase(ALG_BACKPROP, 65536, 65536, 78643, 32768, 3276800, 1, 6554, 250);
        run_phase(ALG_BACKPROP, 0, 0, 78643, 32768, 3276800, 1, 6554, 150);
        run_phase(ALG_RPROP, 45875, 19661, 262144, 0, 2147483647, 0, 2147483647, 250);
        // crossed step bounds
        run_phase(ALG_RPROP, 45875, 19661, 65536, 65536, 0, 2147483647, 0, 200);
        run_phase(ALG_RPROP, $urandom_range(0, 65536), $urandom_range(0, 65536),
                  $urandom_range(65536, 262144), $urandom_range(0, 65536),
                  $urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 65536),
                  $urandom_range(0, 1 << 22), 300);
        run_phase(RST_ALGORITHM, RST_LEARN_RATE, RST_MOMENTUM, RST_INCREASE_FACTOR,
                  RST_DECREASE_FACTOR, RST_STEP_MAX, RST_STEP_MIN, RST_INITIAL_STEP, 150);

        drain();
        repeat (10) @(posedge clk);
        $display("summary: %0d words over %0d register settings, %0d weights checked",
                 in_count, phase_count + 1, out_count);
        $display("summary: both rules, step bounds extreme and crossed, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && weight_expect_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_200_000;
        $display("timeout after %0d words sent, %0d weights returned", in_count, out_count);
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: files.f
src/rprop_swu_pkg.sv
src/rprop_swu_ram.sv
src/rprop_synapse_weight_updater_top.sv
src/rprop_swu_checker.sv
test/testbench.sv
